FILE: hdl/drld_pkg.sv
// -----------------------------------------------------------------------------
// drld_pkg: shared types and constants of the data run list decoder
// Holds the decoder phase encoding, the end reason codes and the state and
// result records that pass between the top level and the step logic.
// -----------------------------------------------------------------------------
`default_nettype none

package drld_pkg;

  // Decoder phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_OFFSET = 4'b0100,
    PH_DRAIN  = 4'b1000
  } phase_t;

  // Reasons why a list has ended.
  localparam logic [2:0] REASON_NONE      = 3'd0;
  localparam logic [2:0] REASON_ZERO_HDR  = 3'd1;
  localparam logic [2:0] REASON_BUF_END   = 3'd2;
  localparam logic [2:0] REASON_MALFORMED = 3'd3;
  localparam logic [2:0] REASON_RUN_LIMIT = 3'd4;

  // Header low-nibble mask and the sign bit of a field byte.
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [7:0] SIGN_MASK   = 8'h80;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  len_size;
    logic [3:0]  off_size;
    logic [3:0]  idx;
    logic [63:0] len_acc;
    logic [63:0] delta_acc;
    logic [63:0] next_vcn;
    logic [63:0] cur_lcn;
    logic [8:0]  runs_done;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:     PH_HEADER,
    len_size:  4'd0,
    off_size:  4'd0,
    idx:       4'd0,
    len_acc:   64'd0,
    delta_acc: 64'd0,
    next_vcn:  64'd0,
    cur_lcn:   64'd0,
    runs_done: 9'd0
  };

  // One result item.
  typedef struct packed {
    logic        run_valid;
    logic [63:0] run_start_vcn;
    logic [63:0] run_start_lcn;
    logic [63:0] run_length;
    logic        is_sparse;
    logic        list_done;
    logic [2:0]  end_reason;
    logic [8:0]  runs_decoded;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/drld_if.sv
// -----------------------------------------------------------------------------
// drld_byte_if / drld_run_if: channel interfaces of the run list decoder
// A valid/ready channel for the incoming bytes and one for the decoded results.
// -----------------------------------------------------------------------------
`default_nettype none

interface drld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface drld_run_if;
  logic        valid;
  logic        ready;
  logic        run_valid;
  logic [63:0] run_start_vcn;
  logic [63:0] run_start_lcn;
  logic [63:0] run_length;
  logic        is_sparse;
  logic        list_done;
  logic [2:0]  end_reason;
  logic [8:0]  runs_decoded;

  modport source (
    output valid, output run_valid, output run_start_vcn, output run_start_lcn,
    output run_length, output is_sparse, output list_done, output end_reason,
    output runs_decoded, input ready
  );
  modport sink (
    input valid, input run_valid, input run_start_vcn, input run_start_lcn,
    input run_length, input is_sparse, input list_done, input end_reason,
    input runs_decoded, output ready
  );
endinterface

`default_nettype wire

FILE: hdl/data_run_list_decoder_unit.sv
// -----------------------------------------------------------------------------
// data_run_list_decoder_unit: streaming mapping-pairs run list decoder
// Decodes a run list one byte per beat and reports each run and the list end.
// -----------------------------------------------------------------------------
// The block takes one byte of a run list per beat and can accept a beat on
// every clock cycle unless the result side stalls. Each byte goes through an
// input register, is decoded combinationally (field merge, sign extension and
// one 64-bit cluster add) and, if it gives a result, the result lands in an
// output register. Bytes that finish a run or end the list give one result
// beat; other bytes give none. After a list ends, bytes are dropped up to the
// byte flagged as last, and the byte after it opens a new list. A stall on the
// result side holds back only bytes that would give a result while the output
// register is still full.
`default_nettype none

module data_run_list_decoder_unit
  import drld_pkg::*;
#(
  parameter int LIST_RUN_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst,
  drld_byte_if.sink   byte_in,
  drld_run_if.source  run_out
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;

  // Decoder state and step outputs.
  state_t  st;
  state_t  st_next;
  logic    has_res;
  result_t res;

  // Output register.
  logic    out_valid;
  result_t out_q;

  drld_step #(.LIST_RUN_LIMIT(LIST_RUN_LIMIT)) u_step (
    .st        (st),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .st_next   (st_next),
    .has_res   (has_res),
    .res       (res)
  );

  // A byte moves on unless it has a result and the output register is stuck.
  assign s1_fire       = s1_valid && (!has_res || !out_valid || run_out.ready);
  assign byte_in.ready = !s1_valid || s1_fire;

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
    if (byte_in.ready && byte_in.valid) begin
      s1_byte <= byte_in.data_byte;
      s1_last <= byte_in.last_byte;
    end
  end

  // Decoder state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && has_res) begin
      out_valid <= 1'b1;
    end else if (run_out.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && has_res) begin
      out_q <= res;
    end
  end

  assign run_out.valid         = out_valid;
  assign run_out.run_valid     = out_q.run_valid;
  assign run_out.run_start_vcn = out_q.run_start_vcn;
  assign run_out.run_start_lcn = out_q.run_start_lcn;
  assign run_out.run_length    = out_q.run_length;
  assign run_out.is_sparse     = out_q.is_sparse;
  assign run_out.list_done     = out_q.list_done;
  assign run_out.end_reason    = out_q.end_reason;
  assign run_out.runs_decoded  = out_q.runs_decoded;

endmodule

`default_nettype wire

FILE: hdl/drld_step.sv
// -----------------------------------------------------------------------------
// drld_step: one-byte step of the mapping-pairs decoder
// Given the current decoder state and one byte, works out the next state and
// whether the byte yields a result, and what that result is.
// -----------------------------------------------------------------------------
`default_nettype none

module drld_step
  import drld_pkg::*;
#(
  parameter int LIST_RUN_LIMIT = 256
) (
  input  state_t      st,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output state_t      st_next,
  output logic        has_res,
  output result_t     res
);

  logic [3:0]  idx_inc;
  logic [63:0] byte_shifted;
  logic [63:0] len_merged;
  logic [63:0] delta_merged;
  logic [63:0] delta_ext;
  logic [63:0] lcn_sum;
  logic [3:0]  len_nib;
  logic [3:0]  off_nib;

  // Field byte placed at its little-endian position; bytes past the eighth drop.
  assign idx_inc      = st.idx + 4'd1;
  assign byte_shifted = st.idx[3] ? 64'd0 : (64'(data_byte) << {st.idx[2:0], 3'b000});
  assign len_merged   = st.len_acc | byte_shifted;
  assign delta_merged = st.delta_acc | byte_shifted;

  // Sign extension of a short offset from its last byte.
  assign delta_ext = (!st.off_size[3] && ((data_byte & SIGN_MASK) != 8'd0))
                   ? (delta_merged | (~64'd0 << {st.off_size[2:0], 3'b000}))
                   : delta_merged;
  assign lcn_sum   = st.cur_lcn + delta_ext;

  assign len_nib = 4'(data_byte & NIBBLE_MASK);
  assign off_nib = data_byte[7:4];

  always_comb begin
    st_next = st;
    has_res = 1'b0;
    res     = '0;

    unique case (st.phase)
      PH_HEADER: begin
        st_next.len_size = len_nib;
        st_next.off_size = off_nib;
        if (data_byte == 8'd0) begin
          has_res          = 1'b1;
          res.list_done    = 1'b1;
          res.end_reason   = REASON_ZERO_HDR;
          res.runs_decoded = st.runs_done;
          st_next.phase    = PH_DRAIN;
        end else if (st.runs_done >= 9'(LIST_RUN_LIMIT)) begin
          has_res          = 1'b1;
          res.list_done    = 1'b1;
          res.end_reason   = REASON_RUN_LIMIT;
          res.runs_decoded = st.runs_done;
          st_next.phase    = PH_DRAIN;
        end else if (len_nib == 4'd0 || last_byte) begin
          has_res          = 1'b1;
          res.list_done    = 1'b1;
          res.end_reason   = REASON_MALFORMED;
          res.runs_decoded = st.runs_done;
          st_next.phase    = PH_DRAIN;
        end else begin
          st_next.idx       = 4'd0;
          st_next.len_acc   = 64'd0;
          st_next.delta_acc = 64'd0;
          st_next.phase     = PH_LENGTH;
        end
      end

      PH_LENGTH: begin
        st_next.len_acc = len_merged;
        st_next.idx     = idx_inc;
        if (idx_inc >= st.len_size) begin
          if (st.off_size == 4'd0) begin
            // Sparse run completes on the last length byte.
            has_res            = 1'b1;
            res.run_valid      = 1'b1;
            res.run_start_vcn  = st.next_vcn;
            res.run_length     = len_merged;
            res.is_sparse      = 1'b1;
            res.runs_decoded   = st.runs_done + 9'd1;
            st_next.next_vcn   = st.next_vcn + len_merged;
            st_next.runs_done  = st.runs_done + 9'd1;
            st_next.phase      = PH_HEADER;
            st_next.idx        = 4'd0;
            st_next.len_acc    = 64'd0;
            st_next.delta_acc  = 64'd0;
            if (last_byte) begin
              res.list_done  = 1'b1;
              res.end_reason = REASON_BUF_END;
            end
          end else if (last_byte) begin
            has_res          = 1'b1;
            res.list_done    = 1'b1;
            res.end_reason   = REASON_MALFORMED;
            res.runs_decoded = st.runs_done;
          end else begin
            st_next.idx   = 4'd0;
            st_next.phase = PH_OFFSET;
          end
        end else if (last_byte) begin
          has_res          = 1'b1;
          res.list_done    = 1'b1;
          res.end_reason   = REASON_MALFORMED;
          res.runs_decoded = st.runs_done;
        end
      end

      PH_OFFSET: begin
        st_next.delta_acc = delta_merged;
        st_next.idx       = idx_inc;
        if (idx_inc >= st.off_size) begin
          // Mapped run completes on the last offset byte.
          has_res            = 1'b1;
          res.run_valid      = 1'b1;
          res.run_start_vcn  = st.next_vcn;
          res.run_start_lcn  = lcn_sum;
          res.run_length     = st.len_acc;
          res.runs_decoded   = st.runs_done + 9'd1;
          st_next.cur_lcn    = lcn_sum;
          st_next.next_vcn   = st.next_vcn + st.len_acc;
          st_next.runs_done  = st.runs_done + 9'd1;
          st_next.phase      = PH_HEADER;
          st_next.idx        = 4'd0;
          st_next.len_acc    = 64'd0;
          st_next.delta_acc  = 64'd0;
          if (last_byte) begin
            res.list_done  = 1'b1;
            res.end_reason = REASON_BUF_END;
          end
        end else if (last_byte) begin
          has_res          = 1'b1;
          res.list_done    = 1'b1;
          res.end_reason   = REASON_MALFORMED;
          res.runs_decoded = st.runs_done;
        end
      end

      PH_DRAIN: begin
        st_next = st;
      end

      default: begin
        st_next = STATE_RESET;
      end
    endcase

    // The flagged last byte always starts a fresh list.
    if (last_byte) begin
      st_next = STATE_RESET;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/drld_checker.sv
// -----------------------------------------------------------------------------
// drld_checker: port-level checks of the run list decoder
// Watches the result channel and checks the consistency of each result beat.
// -----------------------------------------------------------------------------
`default_nettype none

module drld_checker
  import drld_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        run_valid,
  input logic [63:0] run_start_vcn,
  input logic [63:0] run_start_lcn,
  input logic [63:0] run_length,
  input logic        is_sparse,
  input logic        list_done,
  input logic [2:0]  end_reason
);

  // A stalled result beat stays valid and keeps its start VCN, length and end reason.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(run_start_vcn)
      && $stable(run_length) && $stable(end_reason)))
    else $error("result beat changed while stalled");

  // A beat without a run carries zero run fields and must end the list.
  a_norun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !run_valid) |-> (list_done && run_start_vcn == 64'd0
      && run_start_lcn == 64'd0 && run_length == 64'd0 && !is_sparse))
    else $error("empty result beat is not a list end");

  // The end reason is set exactly when the list is done.
  a_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (list_done == (end_reason != REASON_NONE)))
    else $error("end reason disagrees with list done");

  // A run reported with the list end can only end on the buffer end.
  a_runend: assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_valid && list_done) |-> (end_reason == REASON_BUF_END))
    else $error("run ends the list for a reason other than buffer end");

  // A sparse run has no on-disk cluster.
  a_sparse: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_sparse) |-> (run_valid && run_start_lcn == 64'd0))
    else $error("sparse run with a logical cluster");

endmodule

bind data_run_list_decoder_unit drld_checker u_drld_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (run_out.valid),
  .out_ready     (run_out.ready),
  .run_valid     (run_out.run_valid),
  .run_start_vcn (run_out.run_start_vcn),
  .run_start_lcn (run_out.run_start_lcn),
  .run_length    (run_out.run_length),
  .is_sparse     (run_out.is_sparse),
  .list_done     (run_out.list_done),
  .end_reason    (run_out.end_reason)
);

`default_nettype wire
